>>> design/printable_string_extractor_macros.svh
// assertion macros shared by the printable string extractor modules
`ifndef PRINTABLE_STRING_EXTRACTOR_MACROS_SVH
`define PRINTABLE_STRING_EXTRACTOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PSE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define PSE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> design/pse_pkg.sv
// shared types and constants of the printable string extractor
`default_nettype none

package pse_pkg;

	// register and field widths
	localparam int CFG_W = 5;
	localparam int MIN_LENGTH_RESET = 4;
	localparam int MAX_MIN_LENGTH_DEF = 16;

	// index field of a command, wide enough for the largest supported buffer (64)
	localparam int CMD_IDX_W = 6;

	// depth of the command queue between front and back
	localparam int FIFO_DEPTH = 2;

	// printable character range plus horizontal tab
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	// work handed from front to back
	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_PASS,
		CMD_RELEASE,
		CMD_TERM
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t              op;
		logic [7:0]           data;
		logic                 term;
		logic [CMD_IDX_W-1:0] idx;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RELEASE,
		BK_TERM
	} back_state_t;

endpackage

`default_nettype wire

>>> design/pse_if.sv
// valid/ready stream interfaces for input bytes and output characters
`default_nettype none

interface pse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       end_of_data;

	modport source (output valid, output byte_value, output end_of_data, input ready);
	modport sink (input valid, input byte_value, input end_of_data, output ready);
endinterface

interface pse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       string_end;
	logic       last_result;

	modport source (output valid, output char_out, output string_end, output last_result,
		input ready);
	modport sink (input valid, input char_out, input string_end, input last_result,
		output ready);
endinterface

`default_nettype wire

>>> design/pse_cmd_fifo.sv
// small register queue carrying commands from front to back
`default_nettype none
`include "printable_string_extractor_macros.svh"

module pse_cmd_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  pse_pkg::cmd_t     push_cmd,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output pse_pkg::cmd_t     pop_cmd
);

	localparam int DEPTH = pse_pkg::FIFO_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pse_pkg::cmd_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	// handshake status
	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	`PSE_ASSERT_IMP(a_fifo_level, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))

endmodule

`default_nettype wire

>>> design/pse_front.sv
// front end: accepts bytes, tracks the current run and issues commands
`default_nettype none
`include "printable_string_extractor_macros.svh"

module pse_front #(
	parameter int MAX_MIN_LENGTH = pse_pkg::MAX_MIN_LENGTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	pse_in_if.sink                        byte_stream,
	input  wire logic                     cfg_wen,
	input  wire logic [pse_pkg::CFG_W-1:0] cfg_wdata,
	output logic                          push_valid,
	input  wire logic                     push_ready,
	output pse_pkg::cmd_t                 push_cmd
);

	localparam int AW = $clog2(MAX_MIN_LENGTH);
	localparam int CW = $clog2(MAX_MIN_LENGTH + 1);

	logic [pse_pkg::CFG_W-1:0] min_q;
	logic [AW-1:0]             count_q;
	logic                      released_q;
	logic [CW-1:0]             eff_min;
	logic [CW-1:0]             count_inc;
	logic                      printable;
	logic                      reaches_min;
	logic                      accept;
	logic                      need_cmd;

	// classify the incoming byte
	always_comb begin
		printable = byte_stream.byte_value inside
			{[pse_pkg::PRINT_LO:pse_pkg::PRINT_HI], pse_pkg::CHAR_TAB};
	end

	// clamp the minimum length to between one and the buffer size
	always_comb begin
		if (min_q == '0) begin
			eff_min = CW'(1);
		end else if (32'(min_q) > MAX_MIN_LENGTH) begin
			eff_min = CW'(MAX_MIN_LENGTH);
		end else begin
			eff_min = CW'(min_q);
		end
	end

	assign count_inc   = CW'(count_q) + 1'b1;
	assign reaches_min = (count_inc >= eff_min);
	assign accept      = byte_stream.valid && push_ready;
	assign byte_stream.ready = push_ready;

	// command for this byte
	always_comb begin
		need_cmd      = 1'b0;
		push_cmd.op   = pse_pkg::CMD_STORE;
		push_cmd.data = byte_stream.byte_value;
		push_cmd.term = byte_stream.end_of_data;
		push_cmd.idx  = pse_pkg::CMD_IDX_W'(count_q);
		if (printable) begin
			if (released_q) begin
				need_cmd    = 1'b1;
				push_cmd.op = pse_pkg::CMD_PASS;
			end else if (reaches_min) begin
				need_cmd    = 1'b1;
				push_cmd.op = pse_pkg::CMD_RELEASE;
			end else if (!byte_stream.end_of_data) begin
				need_cmd    = 1'b1;
				push_cmd.op = pse_pkg::CMD_STORE;
			end
		end else if (released_q) begin
			need_cmd    = 1'b1;
			push_cmd.op = pse_pkg::CMD_TERM;
		end
	end

	assign push_valid = byte_stream.valid && need_cmd;

	// run tracking and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= pse_pkg::CFG_W'(pse_pkg::MIN_LENGTH_RESET);
			count_q    <= '0;
			released_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				min_q <= cfg_wdata;
			end
			if (accept) begin
				if (!printable || byte_stream.end_of_data) begin
					count_q    <= '0;
					released_q <= 1'b0;
				end else if (!released_q && reaches_min) begin
					count_q    <= '0;
					released_q <= 1'b1;
				end else if (!released_q) begin
					count_q <= AW'(count_inc);
				end
			end
		end
	end

	`PSE_ASSERT_IMP(a_released_empty, clk, arst_n, released_q, count_q == '0)
	`PSE_ASSERT_NXT(a_eod_closes, clk, arst_n, accept && byte_stream.end_of_data,
		!released_q && count_q == '0)

endmodule

`default_nettype wire

>>> design/pse_back.sv
// back end: holds the run prefix and emits characters and terminators
`default_nettype none
`include "printable_string_extractor_macros.svh"

module pse_back #(
	parameter int MAX_MIN_LENGTH = pse_pkg::MAX_MIN_LENGTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	input  pse_pkg::cmd_t pop_cmd,
	pse_out_if.source     char_stream
);

	localparam int AW = $clog2(MAX_MIN_LENGTH);

	pse_pkg::back_state_t state_q;
	pse_pkg::back_state_t state_d;

	logic [7:0]    run_buffer_q [MAX_MIN_LENGTH];
	logic [7:0]    rd_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_d;
	logic [AW-1:0] last_idx_q;
	logic [7:0]    data_q;
	logic          term_q;
	logic          load_cmd;
	logic          mem_we;
	logic          slot_free;
	logic          emit;
	logic [7:0]    e_char;
	logic          e_end;
	logic          e_last;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_end_q;
	logic          out_last_q;

	assign slot_free = !out_valid_q || char_stream.ready;

	// next state, queue pop and emission
	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		pop_ready = 1'b0;
		load_cmd  = 1'b0;
		mem_we    = 1'b0;
		emit      = 1'b0;
		e_char    = '0;
		e_end     = 1'b0;
		e_last    = 1'b0;
		case (state_q)
			pse_pkg::BK_IDLE: begin
				ptr_d = '0;
				if (pop_valid) begin
					case (pop_cmd.op)
						pse_pkg::CMD_STORE: begin
							pop_ready = 1'b1;
							mem_we    = 1'b1;
						end
						pse_pkg::CMD_RELEASE: begin
							pop_ready = 1'b1;
							load_cmd  = 1'b1;
							state_d   = pse_pkg::BK_RELEASE;
						end
						pse_pkg::CMD_PASS: begin
							if (slot_free) begin
								pop_ready = 1'b1;
								emit      = 1'b1;
								e_char    = pop_cmd.data;
								e_last    = !pop_cmd.term;
								if (pop_cmd.term) begin
									state_d = pse_pkg::BK_TERM;
								end
							end
						end
						pse_pkg::CMD_TERM: begin
							if (slot_free) begin
								pop_ready = 1'b1;
								emit      = 1'b1;
								e_end     = 1'b1;
								e_last    = 1'b1;
							end
						end
						default: begin
							pop_ready = 1'b1;
						end
					endcase
				end
			end
			pse_pkg::BK_RELEASE: begin
				if (slot_free) begin
					emit = 1'b1;
					if (ptr_q == last_idx_q) begin
						// the byte that completed the run comes from the command itself
						e_char  = data_q;
						e_last  = !term_q;
						ptr_d   = '0;
						state_d = term_q ? pse_pkg::BK_TERM : pse_pkg::BK_IDLE;
					end else begin
						e_char = rd_q;
						ptr_d  = ptr_q + 1'b1;
					end
				end
			end
			pse_pkg::BK_TERM: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_end   = 1'b1;
					e_last  = 1'b1;
					state_d = pse_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pse_pkg::BK_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pse_pkg::BK_IDLE;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (char_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held command and output payload
	always_ff @(posedge clk) begin
		if (load_cmd) begin
			data_q     <= pop_cmd.data;
			term_q     <= pop_cmd.term;
			last_idx_q <= AW'(pop_cmd.idx);
		end
		if (emit) begin
			out_char_q <= e_char;
			out_end_q  <= e_end;
			out_last_q <= e_last;
		end
	end

	// run prefix buffer with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			run_buffer_q[AW'(pop_cmd.idx)] <= pop_cmd.data;
		end
		rd_q <= run_buffer_q[ptr_d];
	end

	assign char_stream.valid       = out_valid_q;
	assign char_stream.char_out    = out_char_q;
	assign char_stream.string_end  = out_end_q;
	assign char_stream.last_result = out_last_q;

	`PSE_ASSERT_IMP(a_term_is_last, clk, arst_n, out_valid_q && out_end_q,
		out_last_q && out_char_q == '0)
	`PSE_ASSERT_IMP(a_ptr_in_run, clk, arst_n, state_q == pse_pkg::BK_RELEASE,
		ptr_q <= last_idx_q)

endmodule

`default_nettype wire

>>> design/printable_string_extractor.sv
// Printable string extractor: finds runs of printable bytes in a byte stream.
// byte_stream carries one data byte per transaction with an end_of_data flag;
// char_stream carries the characters of each reported string, then a
// terminator transaction (string_end = 1, char_out = 0). last_result marks the
// final transaction caused by one input byte. cfg_wen/cfg_wdata write
// min_length (reset 4), taken as 1 when zero and capped at MAX_MIN_LENGTH.
// A passed-through character reaches char_stream through the command queue
// and the output register. The front takes one byte per cycle while the
// command queue has room; a byte that completes a run occupies the back end
// for the command pop, then one character per cycle from the prefix memory
// while char_stream takes them, then the command's own character, and a
// terminator follows when the string ends. The two-entry command queue lets the
// front queue up to two more commands meanwhile before byte_stream.ready falls.
// Reset clears the run state and the output valid flag; the prefix buffer is
// not cleared, only entries written in the current run are read.
// When char_stream stalls, the output register holds its transaction, the
// back end stops emitting, and byte_stream.ready falls once the queue is full.
`default_nettype none

module printable_string_extractor #(
	parameter int MAX_MIN_LENGTH = pse_pkg::MAX_MIN_LENGTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	pse_in_if.sink                         byte_stream,
	pse_out_if.source                      char_stream,
	input  wire logic                      cfg_wen,
	input  wire logic [pse_pkg::CFG_W-1:0] cfg_wdata
);

	logic          push_valid;
	logic          push_ready;
	pse_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	pse_pkg::cmd_t pop_cmd;

	// classification and run tracking
	pse_front #(
		.MAX_MIN_LENGTH(MAX_MIN_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	pse_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// prefix buffer and output sequencing
	pse_back #(
		.MAX_MIN_LENGTH(MAX_MIN_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.char_stream(char_stream)
	);

endmodule

`default_nettype wire

>>> verif/printable_string_extractor_tb.sv
// self-checking testbench for the printable string extractor
`timescale 1ns / 100ps

module printable_string_extractor_tb;

	localparam int MAXL = pse_pkg::MAX_MIN_LENGTH_DEF;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AT = 150;
	localparam int HOLD_MIN_PENDING = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_PHASE_BYTES = 28;
	localparam int MAX_REPORTS = 60;
	localparam longint TIMEOUT_NS = 64'd12_000_000;

	typedef struct {
		logic [7:0] value;
		logic       eod;
	} data_byte_t;

	typedef struct {
		logic [7:0] ch;
		logic       term;
		logic       last;
	} char_item_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [pse_pkg::CFG_W-1:0] cfg_wdata;

	pse_in_if  byte_if();
	pse_out_if char_if();

	printable_string_extractor dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_if),
		.char_stream (char_if),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata)
	);

	// pending bytes and expected output characters
	data_byte_t bytes_to_send[$];
	char_item_t expected_chars[$];

	// own copy of the extractor state
	logic [7:0]                held_bytes[MAXL];
	int                        held_count;
	logic                      run_released;
	logic [pse_pkg::CFG_W-1:0] min_length_copy;

	int errors;
	int bytes_accepted;
	int chars_checked;
	int strings_closed;
	int settings_written;
	int input_stall_cycles;

	// driver and receiver pacing
	int send_gap;
	int send_quiet;
	int take_gap;
	int take_quiet;
	int hold_left;
	bit hold_done;
	data_byte_t next_byte;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// random gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rand_printable();
		if ($urandom_range(0, 15) == 0)
			return pse_pkg::CHAR_TAB;
		return 8'($urandom_range(32, 126));
	endfunction

	// any byte outside the printable set
	function automatic logic [7:0] rand_control();
		int v;
		v = $urandom_range(0, 159);
		if (v < 9)
			return 8'(v);
		else if (v < 31)
			return 8'(v + 1);
		else
			return 8'(v + 96);
	endfunction

	function automatic int effective_min(input logic [pse_pkg::CFG_W-1:0] m);
		if (m < 1)
			return 1;
		if (m > MAXL)
			return MAXL;
		return m;
	endfunction

	// expected output transactions for one accepted data byte
	task automatic predict_strings(input logic [7:0] b, input logic eod);
		char_item_t items[$];
		logic printable;
		int eff;
		printable = (b >= pse_pkg::PRINT_LO && b <= pse_pkg::PRINT_HI) ||
			b == pse_pkg::CHAR_TAB;
		eff = effective_min(min_length_copy);
		if (printable) begin
			if (run_released) begin
				items.insert(items.size(), '{b, 1'b0, 1'b0});
			end else begin
				if (held_count < MAXL) begin
					held_bytes[held_count] = b;
					held_count++;
				end
				if (held_count >= eff) begin
					for (int i = 0; i < held_count; i++)
						items.insert(items.size(), '{held_bytes[i], 1'b0, 1'b0});
					held_count = 0;
					run_released = 1'b1;
				end
			end
		end
		if (!printable || eod) begin
			if (run_released)
				items.insert(items.size(), '{8'h00, 1'b1, 1'b0});
			run_released = 1'b0;
			held_count = 0;
		end
		if (items.size() > 0)
			items[items.size() - 1].last = 1'b1;
		foreach (items[k])
			expected_chars.insert(expected_chars.size(), items[k]);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic eod);
		bytes_to_send.insert(bytes_to_send.size(), '{b, eod});
	endtask

	// mostly well-formed runs around min_length, with some noise
	task automatic queue_random_bytes(input int n, input int eff);
		int sent;
		int len;
		int r;
		bit eod_on_last;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 80) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, eff + 3);
				else if (r < 90)
					len = $urandom_range(eff, eff + 12);
				else
					len = $urandom_range(1, (eff > 1) ? eff - 1 : 1);
				eod_on_last = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < len; k++)
					queue_byte(rand_printable(), eod_on_last && k == len - 1);
				sent += len;
				if (!eod_on_last) begin
					queue_byte(rand_control(), $urandom_range(0, 7) == 0);
					sent++;
				end
			end else begin
				queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				sent++;
			end
		end
		// leave a run open so the next setting lands mid-run
		if ($urandom_range(0, 1) == 1) begin
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++)
				queue_byte(rand_printable(), 1'b0);
		end
	endtask

	// wait until every byte is sent and every expectation met, then let the block settle
	task automatic wait_until_idle();
		do begin
			while (bytes_to_send.size() != 0 || byte_if.valid || expected_chars.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end while (bytes_to_send.size() != 0 || byte_if.valid || expected_chars.size() != 0);
	endtask

	task automatic write_min_length(input logic [pse_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		min_length_copy = v;
		settings_written++;
	endtask

	// reset and stimulus
	initial begin
		logic [pse_pkg::CFG_W-1:0] random_settings[$];
		logic [pse_pkg::CFG_W-1:0] v;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		byte_if.valid = 1'b0;
		byte_if.byte_value = 8'h00;
		byte_if.end_of_data = 1'b0;
		char_if.ready = 1'b0;
		held_count = 0;
		run_released = 1'b0;
		min_length_copy = pse_pkg::CFG_W'(pse_pkg::MIN_LENGTH_RESET);
		foreach (held_bytes[i])
			held_bytes[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset length: range edges and tab make a string, short run dropped
		queue_byte(8'h20, 1'b0);
		queue_byte(8'h7E, 1'b0);
		queue_byte(pse_pkg::CHAR_TAB, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h62, 1'b0);
		queue_byte(8'hFF, 1'b0);
		wait_until_idle();

		// length one: printable byte with end of data, control byte with end of data
		write_min_length(5'd1);
		queue_byte(8'h1F, 1'b0);
		queue_byte(8'h7E, 1'b1);
		queue_byte(8'h08, 1'b1);
		wait_until_idle();

		// length zero behaves as one
		write_min_length(5'd0);
		queue_byte(8'h30, 1'b0);
		queue_byte(8'h31, 1'b0);
		queue_byte(8'h80, 1'b1);
		wait_until_idle();

		// lowered mid-run: next printable byte releases the held prefix
		write_min_length(5'd8);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'h42, 1'b0);
		queue_byte(8'h43, 1'b0);
		queue_byte(8'h44, 1'b0);
		queue_byte(8'h45, 1'b0);
		wait_until_idle();
		write_min_length(5'd3);
		queue_byte(8'h46, 1'b0);
		queue_byte(8'h47, 1'b1);
		queue_byte(8'h0D, 1'b0);
		wait_until_idle();

		// random phases over several settings, extremes included
		random_settings = {5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17,
			5'($urandom_range(0, 31)), 5'd3, 5'($urandom_range(0, 31))};
		foreach (random_settings[p]) begin
			v = random_settings[p];
			write_min_length(v);
			queue_random_bytes(RANDOM_PHASE_BYTES, effective_min(v));
			wait_until_idle();
		end

		$display("covered %0d input bytes, %0d characters and %0d string terminators",
			bytes_accepted, chars_checked, strings_closed);
		$display("over %0d min_length settings; input stalled for %0d cycles",
			settings_written, input_stall_cycles);
		if (errors == 0 && expected_chars.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
		end else begin
			if (byte_if.valid && byte_if.ready) begin
				predict_strings(byte_if.byte_value, byte_if.end_of_data);
				bytes_accepted++;
			end
			if (byte_if.valid && !byte_if.ready)
				input_stall_cycles++;
			if (!byte_if.valid || byte_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					byte_if.valid <= 1'b0;
				end else if (bytes_to_send.size() > 0) begin
					next_byte = bytes_to_send.pop_front();
					byte_if.valid <= 1'b1;
					byte_if.byte_value <= next_byte.value;
					byte_if.end_of_data <= next_byte.eod;
					// stretches of back-to-back transactions
					if (send_quiet > 0)
						send_quiet--;
					else if ($urandom_range(0, 49) == 0)
						send_quiet = $urandom_range(20, 60);
					send_gap = (send_quiet > 0) ? 0 : pick_gap();
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with one long hold-off to fill the block
	always @(posedge clk) begin
		if (!arst_n) begin
			char_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			char_if.ready <= 1'b0;
		end else if (!hold_done && bytes_accepted >= HOLD_AT &&
				bytes_to_send.size() > HOLD_MIN_PENDING) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			char_if.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			char_if.ready <= 1'b0;
		end else begin
			char_if.ready <= 1'b1;
			if (take_quiet > 0)
				take_quiet--;
			else if ($urandom_range(0, 99) == 0)
				take_quiet = $urandom_range(30, 80);
			else
				take_gap = pick_gap();
		end
	end

	// output monitor
	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && char_if.valid && char_if.ready) begin
			if (expected_chars.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: extra transaction: expected none, actual %h/%b/%b",
						$time, char_if.char_out, char_if.string_end,
						char_if.last_result);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (char_if.char_out !== want.ch) begin
					if (errors < MAX_REPORTS)
						$display("%0t: char_out mismatch: expected %h, actual %h",
							$time, want.ch, char_if.char_out);
					errors++;
				end
				if (char_if.string_end !== want.term) begin
					if (errors < MAX_REPORTS)
						$display("%0t: string_end mismatch: expected %b, actual %b",
							$time, want.term, char_if.string_end);
					errors++;
				end
				if (char_if.last_result !== want.last) begin
					if (errors < MAX_REPORTS)
						$display("%0t: last_result mismatch: expected %b, actual %b",
							$time, want.last, char_if.last_result);
					errors++;
				end
				if (want.term)
					strings_closed++;
				else
					chars_checked++;
			end
		end
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d bytes pending and %0d transactions expected",
			$time, bytes_to_send.size(), expected_chars.size());
		$display("status: fail");
		$finish;
	end

endmodule
